// ===== rtl/core/rtct_pkg.sv =====
// Types and constants shared by the recordable transfer curve table.
`default_nettype none

package rtct_pkg;

  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W = 8;
  localparam int TABLE_DEPTH = 2 ** LEVEL_W;

  localparam int FULL_SCALE = 930;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [LEVEL_W-1:0] Y_RESET = 8'd220;

  localparam int PROD_W = SAMPLE_W + LEVEL_W;
  localparam int SCALE_SHIFT = 29;
  localparam longint SCALE_RECIP = ((64'd1 << SCALE_SHIFT) + FULL_SCALE - 1) / FULL_SCALE;
  localparam int RECIP_W = $clog2(SCALE_RECIP + 1);
  localparam int MUL_W = PROD_W + RECIP_W;
  localparam int QUOT_W = MUL_W - SCALE_SHIFT;

  typedef enum logic [1:0] {
    MODE_LOW  = 2'd0,
    MODE_HIGH = 2'd1,
    MODE_PWM  = 2'd2
  } drive_mode_e;

  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] sample;
    logic                recording;
  } in_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    drive_mode_e        drive_mode;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/core/rtct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rtct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/recordable_transfer_curve_table.sv =====
// Top level of the recordable transfer curve table.
//
// Takes one beat per cycle, poll or converter reading, unless stalled, and
// returns exactly one result beat per input beat via the first-stage and the
// output registers. The reading is scaled by a constant reciprocal multiply in
// the first stage, the x/y registers and the 256 x 8 curve RAM are updated
// there, and the RAM's registered read feeds the output stage. One valid flag
// per table entry makes unwritten entries read as zero, so no clearing pass
// runs after reset. A waiting result stalls input only while stage one is full.
`default_nettype none

module recordable_transfer_curve_table import rtct_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic               in_fire;
  logic               s1_valid_q, s1_valid_d;
  logic               s1_kind_q;
  logic               s1_rec_q;
  logic [PROD_W-1:0]  s1_prod_q;
  logic               s1_fire;
  logic               s2_en;

  logic               next_is_y_q, next_is_y_d;
  logic [LEVEL_W-1:0] x_q, x_d;
  logic [LEVEL_W-1:0] y_q, y_d;

  logic [MUL_W-1:0]   mul;
  logic [QUOT_W-1:0]  quot;
  logic [LEVEL_W-1:0] scaled;

  logic [TABLE_DEPTH-1:0] filled_q;
  logic                   we;
  logic [LEVEL_W-1:0]     ram_rdata;

  logic               s2_valid_q, s2_valid_d;
  logic               s2_rec_q;
  logic               s2_filled_q;
  logic [LEVEL_W-1:0] s2_y_q;
  logic [LEVEL_W-1:0] level;

  // handshake
  assign s2_en      = !s2_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s2_en;
  assign in_stall_o = s1_valid_q && !s2_en;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    s2_valid_d = s2_valid_q;
    if (s1_fire) begin
      s2_valid_d = 1'b1;
    end else if (s2_valid_q && !out_stall_i) begin
      s2_valid_d = 1'b0;
    end
  end

  // scale: sample * 255 / FULL_SCALE via reciprocal, saturate
  assign mul    = MUL_W'(s1_prod_q) * MUL_W'(SCALE_RECIP);
  assign quot   = mul[MUL_W-1:SCALE_SHIFT];
  assign scaled = (quot > QUOT_W'(LEVEL_MAX)) ? LEVEL_MAX : quot[LEVEL_W-1:0];

  always_comb begin
    next_is_y_d = next_is_y_q;
    x_d         = x_q;
    y_d         = y_q;
    if (s1_kind_q) begin
      next_is_y_d = !next_is_y_q;
      if (next_is_y_q) begin
        y_d = scaled;
      end else begin
        x_d = scaled;
      end
    end
  end

  assign we = s1_fire && s1_rec_q;

  rtct_ram #(
    .WIDTH(LEVEL_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(x_d[ADDR_W-1:0]),
    .wdata_i(y_d),
    .re_i   (s1_fire),
    .raddr_i(x_d[ADDR_W-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      next_is_y_q <= 1'b1;
      x_q         <= '0;
      y_q         <= Y_RESET;
      filled_q    <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
      if (s1_fire) begin
        next_is_y_q <= next_is_y_d;
        x_q         <= x_d;
        y_q         <= y_d;
      end
      if (we) begin
        filled_q[x_d[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= in_data_i.kind;
      s1_rec_q  <= in_data_i.recording;
      s1_prod_q <= {in_data_i.sample, LEVEL_W'(0)} - PROD_W'(in_data_i.sample);
    end
    if (s1_fire) begin
      s2_rec_q    <= s1_rec_q;
      s2_y_q      <= y_d;
      s2_filled_q <= filled_q[x_d[ADDR_W-1:0]];
    end
  end

  // take own write first, else stored entry, else cleared value
  assign level = s2_rec_q ? s2_y_q : (s2_filled_q ? ram_rdata : '0);

  always_comb begin
    out_data_o.level = level;
    priority if (level == '0) begin
      out_data_o.drive_mode = MODE_LOW;
    end else if (level == LEVEL_MAX) begin
      out_data_o.drive_mode = MODE_HIGH;
    end else begin
      out_data_o.drive_mode = MODE_PWM;
    end
  end

  assign out_valid_o = s2_valid_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && s2_valid_q)
    else $error("input stalled with free first stage");

  a_channel_toggles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_kind_q |=> next_is_y_q != $past(next_is_y_q))
    else $error("y/x channel order did not advance on a reading");

  a_record_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_rec_q |=> out_valid_o && out_data_o.level == $past(y_d))
    else $error("recorded beat did not return the written y value");

  a_poll_keeps_xy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && !s1_kind_q |=> $stable(x_q) && $stable(y_q) && $stable(next_is_y_q))
    else $error("poll beat changed the x/y registers");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the recordable transfer curve table: directed and random beats vs. a predictor.
module tb;
  import rtct_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_BEATS = 1350;
  localparam int DRAIN_CYCLES = 8;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  logic               y_turn;
  logic [LEVEL_W-1:0] pos_x;
  logic [LEVEL_W-1:0] held_y;
  logic [LEVEL_W-1:0] curve_mem [TABLE_DEPTH];
  out_t               level_q [$];
  int                 errors;
  bit                 send_calm;
  bit                 take_calm;

  recordable_transfer_curve_table i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [LEVEL_W-1:0] to_level(input logic [SAMPLE_W-1:0] raw);
    int prod;
    prod = int'(raw) * int'(LEVEL_MAX) / FULL_SCALE;
    if (prod > int'(LEVEL_MAX)) return LEVEL_MAX;
    return prod[LEVEL_W-1:0];
  endfunction

  function automatic out_t apply_curve_step(input in_t beat);
    out_t res;
    if (beat.kind) begin
      if (y_turn) held_y = to_level(beat.sample);
      else pos_x = to_level(beat.sample);
      y_turn = !y_turn;
    end
    if (beat.recording) curve_mem[pos_x] = held_y;
    res.level = curve_mem[pos_x];
    if (res.level == '0) res.drive_mode = MODE_LOW;
    else if (res.level == LEVEL_MAX) res.drive_mode = MODE_HIGH;
    else res.drive_mode = MODE_PWM;
    return res;
  endfunction

  function automatic in_t make_beat(input logic kind, input logic [SAMPLE_W-1:0] sample,
                                    input logic recording);
    in_t beat;
    beat.kind = kind;
    beat.sample = sample;
    beat.recording = recording;
    return beat;
  endfunction

  function automatic int draw_gap(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_reading();
    int pick;
    pick = $urandom_range(0, 7);
    case (pick)
      0: begin
        return SAMPLE_W'($urandom_range(900, 1023));
      end
      1: begin
        return SAMPLE_W'($urandom_range(0, 8));
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return 10'd0;
          1: return 10'd465;
          2: return 10'd929;
          default: return 10'd1023;
        endcase
      end
      default: begin
        return SAMPLE_W'($urandom_range(0, 1023));
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic send_beat(input in_t beat);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = draw_gap(send_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (in_stall_o);
    level_q.push_back(apply_curve_step(beat));
  endtask

  task automatic test_cleared_table();
    send_beat(make_beat(1'b0, 10'h3FF, 1'b0));
    send_beat(make_beat(1'b0, 10'h000, 1'b0));
  endtask

  task automatic test_reset_y_written();
    send_beat(make_beat(1'b0, 10'h155, 1'b1));
  endtask

  task automatic test_scale_extremes();
    send_beat(make_beat(1'b1, 10'd1023, 1'b0));
    send_beat(make_beat(1'b1, 10'd0, 1'b1));
    send_beat(make_beat(1'b1, 10'd930, 1'b0));
    send_beat(make_beat(1'b1, 10'd1023, 1'b1));
    send_beat(make_beat(1'b1, 10'd929, 1'b0));
    send_beat(make_beat(1'b1, 10'd929, 1'b1));
    send_beat(make_beat(1'b1, 10'd0, 1'b0));
    send_beat(make_beat(1'b1, 10'd4, 1'b1));
    send_beat(make_beat(1'b1, 10'd4, 1'b0));
    send_beat(make_beat(1'b1, 10'd2, 1'b1));
  endtask

  task automatic test_new_x_write_order();
    send_beat(make_beat(1'b1, 10'd512, 1'b0));
    send_beat(make_beat(1'b1, 10'd300, 1'b1));
    send_beat(make_beat(1'b1, 10'd100, 1'b0));
    send_beat(make_beat(1'b1, 10'd300, 1'b0));
  endtask

  task automatic test_poll_keeps_phase();
    send_beat(make_beat(1'b1, 10'd700, 1'b0));
    send_beat(make_beat(1'b0, 10'h2AA, 1'b1));
    send_beat(make_beat(1'b0, 10'd1023, 1'b0));
    send_beat(make_beat(1'b1, 10'd0, 1'b0));
  endtask

  task automatic test_random_curves();
    int sent;
    int pick;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_beat(make_beat(1'b1, rand_reading(), ($urandom_range(0, 3) == 0)));
        if ($urandom_range(0, 3) == 0) begin
          send_beat(make_beat(1'b0, rand_reading(), 1'($urandom_range(0, 1))));
          sent++;
        end
        send_beat(make_beat(1'b1, rand_reading(), 1'($urandom_range(0, 1))));
        sent += 2;
      end else if (pick < 9) begin
        send_beat(make_beat(1'b0, SAMPLE_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1))));
        sent++;
      end else begin
        send_beat(make_beat(1'b1, rand_reading(), 1'($urandom_range(0, 1))));
        sent++;
      end
    end
  endtask

  initial begin
    int hold;
    out_t want;
    hold = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (level_q.size() == 0) begin
          report_mismatch("beat with nothing expected, level", int'(out_data_o.level), -1);
        end else begin
          want = level_q.pop_front();
          if (out_data_o.level !== want.level)
            report_mismatch("level", int'(out_data_o.level), int'(want.level));
          if (out_data_o.drive_mode !== want.drive_mode)
            report_mismatch("drive mode", int'(out_data_o.drive_mode), int'(want.drive_mode));
        end
        if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
        hold = draw_gap(take_calm);
      end
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle = 0;
      else idle++;
    end
    $display("recordable_transfer_curve_table: mismatch");
    $finish;
  end

  initial begin
    errors = 0;
    send_calm = 1'b0;
    take_calm = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    y_turn = 1'b1;
    pos_x = '0;
    held_y = Y_RESET;
    for (int k = 0; k < TABLE_DEPTH; k++) curve_mem[k] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_cleared_table();
    test_reset_y_written();
    test_scale_extremes();
    test_new_x_write_order();
    test_poll_keeps_phase();
    test_random_curves();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (level_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("recordable_transfer_curve_table: match");
    end else begin
      $display("recordable_transfer_curve_table: mismatch");
    end
    $finish;
  end

endmodule
